@@ sv/rwmm_pkg.sv @@
// shared types and constants for the ring window min/max block
`timescale 1ns / 1ps

package rwmm_pkg;

	localparam int MAX_DEPTH_DEF = 64;
	localparam int WIN_W         = 7;
	localparam int DATA_W        = 32;
	localparam int CMD_W         = 2;
	localparam int KIND_W        = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH    = 2'd0,
		CMD_MINMAX  = 2'd1,
		CMD_READOUT = 2'd2
	} cmd_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_MINMAX = 2'd0,
		KIND_SAMPLE = 2'd1,
		KIND_EMPTY  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MM_SCAN,
		S_MM_OUT,
		S_ERR_OUT,
		S_RO_ISSUE,
		S_RO_WAIT
	} state_t;

	typedef struct packed {
		logic push;
		logic start;
		logic issue;
		logic load_mm;
		logic load_err;
		logic load_sample;
	} dp_cmd_t;

	typedef struct packed {
		logic held_zero;
		logic rem_zero;
		logic scan_last;
		logic sel_last;
		logic out_free;
	} dp_sts_t;

endpackage

@@ sv/rwmm_in_if.sv @@
// input channel: command word with sample
`timescale 1ns / 1ps

interface rwmm_in_if
	import rwmm_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic signed [DATA_W-1:0] sample_value;

	modport source (output valid, output command, output sample_value, input ready);
	modport sink   (input valid, input command, input sample_value, output ready);
endinterface

@@ sv/rwmm_out_if.sv @@
// output channel: result word
`timescale 1ns / 1ps

interface rwmm_out_if
	import rwmm_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic [KIND_W-1:0]        result_kind;
	logic signed [DATA_W-1:0] first_value;
	logic signed [DATA_W-1:0] second_value;
	logic                     last_of_run;

	modport source (output valid, output result_kind, output first_value,
		output second_value, output last_of_run, input ready);
	modport sink   (input valid, input result_kind, input first_value,
		input second_value, input last_of_run, output ready);
endinterface

@@ sv/ring_window_min_max_core.sv @@
// Ring window min/max core. Keeps the last window_size samples (1 to MAX_DEPTH, clamped;
// writing the size empties the ring) in a ring memory with one write and one read port.
// A push leaves the core idle and ready for the next command. A min/max query walks the
// held samples one per cycle through the memory read port and then delivers one word,
// waiting while the output is stalled; on an empty ring it answers with an empty-kind
// word. A readout streams one word per cycle while the output is not stalled, oldest
// first, and delivers no word on an empty ring. Only one command is worked on at a time;
// a push is taken while an earlier result still waits at the output.
`timescale 1ns / 1ps

module ring_window_min_max_core
	import rwmm_pkg::*;
#(
	parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	rwmm_in_if.sink          sample_ch,
	rwmm_out_if.source       result_ch,
	input  logic             cfg_wr_en,
	input  logic [WIN_W-1:0] cfg_wr_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	rwmm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (sample_ch.valid),
		.in_command (sample_ch.command),
		.in_ready   (sample_ch.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	rwmm_dp #(
		.MAX_DEPTH (MAX_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.sample      (sample_ch.sample_value),
		.cmd         (cmd),
		.sts         (sts),
		.out_ready   (result_ch.ready),
		.out_valid   (result_ch.valid),
		.out_kind    (result_ch.result_kind),
		.out_first   (result_ch.first_value),
		.out_second  (result_ch.second_value),
		.out_last    (result_ch.last_of_run)
	);

endmodule

@@ sv/rwmm_dp.sv @@
// datapath: ring memory, indexes, fill count, min/max accumulators, output register
`timescale 1ns / 1ps

module rwmm_dp
	import rwmm_pkg::*;
#(
	parameter int MAX_DEPTH = MAX_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [WIN_W-1:0]         cfg_wr_data,
	input  logic signed [DATA_W-1:0] sample,
	input  dp_cmd_t                  cmd,
	output dp_sts_t                  sts,
	input  logic                     out_ready,
	output logic                     out_valid,
	output logic [KIND_W-1:0]        out_kind,
	output logic signed [DATA_W-1:0] out_first,
	output logic signed [DATA_W-1:0] out_second,
	output logic                     out_last
);

	localparam int AW = $clog2(MAX_DEPTH);
	localparam int CW = $clog2(MAX_DEPTH + 1);

	logic [DATA_W-1:0] mem [MAX_DEPTH];

	logic [CW-1:0]            size_q;
	logic [AW-1:0]            wi_q;
	logic [CW-1:0]            fill_q;
	logic [AW-1:0]            ptr_q;
	logic [CW-1:0]            rem_q;
	logic                     first_q;
	logic                     vld_s1;
	logic                     first_s1;
	logic                     last_s1;
	logic signed [DATA_W-1:0] mem_s1;
	logic signed [DATA_W-1:0] mn_q;
	logic signed [DATA_W-1:0] mx_q;

	logic                     ovalid_q;
	kind_t                    kind_q;
	logic signed [DATA_W-1:0] first_val_q;
	logic signed [DATA_W-1:0] second_val_q;
	logic                     last_q;

	logic [CW-1:0] eff_size;
	logic [CW:0]   oldest_sum;
	logic [AW-1:0] oldest;
	logic [CW-1:0] wi_inc;
	logic [AW-1:0] wi_next;
	logic [CW-1:0] ptr_inc;
	logic [AW-1:0] ptr_next;
	logic          out_free;

	// window size clamp to 1..MAX_DEPTH
	always_comb begin
		priority if (cfg_wr_data == '0) begin
			eff_size = CW'(1);
		end else if (cfg_wr_data > WIN_W'(MAX_DEPTH)) begin
			eff_size = CW'(MAX_DEPTH);
		end else begin
			eff_size = CW'(cfg_wr_data);
		end
	end

	always_comb begin
		if (CW'(wi_q) >= fill_q) begin
			oldest_sum = (CW+1)'(CW'(wi_q) - fill_q);
		end else begin
			oldest_sum = (CW+1)'(wi_q) + (CW+1)'(size_q) - (CW+1)'(fill_q);
		end
		oldest  = oldest_sum[AW-1:0];
		wi_inc  = CW'(wi_q) + CW'(1);
		wi_next = (wi_inc == size_q) ? '0 : wi_inc[AW-1:0];
		ptr_inc  = CW'(ptr_q) + CW'(1);
		ptr_next = (ptr_inc == size_q) ? '0 : ptr_inc[AW-1:0];
	end

	// ring memory
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wi_q] <= sample;
		end
		if (cmd.issue) begin
			mem_s1 <= mem[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= CW'(MAX_DEPTH);
			wi_q   <= '0;
			fill_q <= '0;
		end else if (cfg_wr_en) begin
			size_q <= eff_size;
			wi_q   <= '0;
			fill_q <= '0;
		end else if (cmd.push) begin
			wi_q <= wi_next;
			if (fill_q < size_q) begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	// scan pointer and remaining count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q    <= '0;
			rem_q    <= '0;
			first_q  <= 1'b0;
			vld_s1   <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			if (cmd.start) begin
				ptr_q   <= oldest;
				rem_q   <= fill_q;
				first_q <= 1'b1;
			end else if (cmd.issue) begin
				ptr_q    <= ptr_next;
				rem_q    <= rem_q - CW'(1);
				first_q  <= 1'b0;
				first_s1 <= first_q;
				last_s1  <= (rem_q == CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			if (first_s1 || (mem_s1 < mn_q)) begin
				mn_q <= mem_s1;
			end
			if (first_s1 || (mem_s1 > mx_q)) begin
				mx_q <= mem_s1;
			end
		end
	end

	assign out_free = !ovalid_q || out_ready;

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.load_mm || cmd.load_err || cmd.load_sample) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.load_mm) begin
			kind_q       <= KIND_MINMAX;
			first_val_q  <= mn_q;
			second_val_q <= mx_q;
			last_q       <= 1'b1;
		end else if (cmd.load_err) begin
			kind_q       <= KIND_EMPTY;
			first_val_q  <= '0;
			second_val_q <= '0;
			last_q       <= 1'b1;
		end else if (cmd.load_sample) begin
			kind_q       <= KIND_SAMPLE;
			first_val_q  <= mem_s1;
			second_val_q <= '0;
			last_q       <= last_s1;
		end else begin
			kind_q       <= kind_q;
		end
	end

	assign out_valid  = ovalid_q;
	assign out_kind   = kind_q;
	assign out_first  = first_val_q;
	assign out_second = second_val_q;
	assign out_last   = last_q;

	assign sts.held_zero = (fill_q == '0);
	assign sts.rem_zero  = (rem_q == '0);
	assign sts.scan_last = vld_s1 && last_s1;
	assign sts.sel_last  = last_s1;
	assign sts.out_free  = out_free;

`ifndef NO_ASSERTIONS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= size_q)
		else $error("fill count above window size");
	a_wi_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(wi_q) < size_q)
		else $error("write index outside window");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> rem_q != '0)
		else $error("read issued with nothing left to scan");
	a_fill_grow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push && !cfg_wr_en && (fill_q < size_q) |=> fill_q == $past(fill_q) + CW'(1))
		else $error("push did not grow fill count");
`endif

endmodule

@@ sv/rwmm_ctrl.sv @@
// controller state machine: command decode and scan/readout sequencing
`timescale 1ns / 1ps

module rwmm_ctrl
	import rwmm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] in_command,
	output logic             in_ready,
	input  dp_sts_t          sts,
	output dp_cmd_t          cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_command)
						CMD_MINMAX:  state_next = sts.held_zero ? S_ERR_OUT : S_MM_SCAN;
						CMD_READOUT: state_next = sts.held_zero ? S_IDLE : S_RO_ISSUE;
						default:     state_next = S_IDLE;
					endcase
				end
			end
			S_MM_SCAN: begin
				if (sts.scan_last) begin
					state_next = S_MM_OUT;
				end
			end
			S_MM_OUT, S_ERR_OUT: begin
				if (sts.out_free) begin
					state_next = S_IDLE;
				end
			end
			S_RO_ISSUE: state_next = S_RO_WAIT;
			S_RO_WAIT: begin
				if (sts.out_free && sts.sel_last) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_command)
						CMD_PUSH:    cmd.push  = 1'b1;
						CMD_MINMAX:  cmd.start = !sts.held_zero;
						CMD_READOUT: cmd.start = !sts.held_zero;
						default:     cmd.push  = 1'b0;
					endcase
				end
			end
			S_MM_SCAN:  cmd.issue    = !sts.rem_zero;
			S_MM_OUT:   cmd.load_mm  = sts.out_free;
			S_ERR_OUT:  cmd.load_err = sts.out_free;
			S_RO_ISSUE: cmd.issue    = 1'b1;
			S_RO_WAIT: begin
				cmd.load_sample = sts.out_free;
				cmd.issue       = sts.out_free && !sts.sel_last;
			end
			default: cmd = '0;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> in_valid && in_ready)
		else $error("push outside an accepted word");
	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_mm, cmd.load_err, cmd.load_sample}))
		else $error("more than one output load");
	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MM_SCAN && sts.scan_last |=> state_q == S_MM_OUT)
		else $error("scan end missed");
`endif

endmodule
